// ===== rtl/vdi_pkg.sv =====
// ----------------------------------------------------------------------------
// vdi_pkg
// Shared types, constants and float helpers for the vertex dedup indexer.
// ----------------------------------------------------------------------------
package vdi_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned VERTEX_W    = 3 * COORD_W;
  localparam int unsigned INDEX_W     = 10;

  typedef struct packed {
    logic               start_mesh;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] vertex_index;
    logic               is_new;
    logic               table_overflow;
  } out_item_t;

  // classified item: coord is {x, y, z}, is_zero[2] belongs to x
  typedef struct packed {
    logic                start;
    logic                any_nan;
    logic [2:0]          is_zero;
    logic [VERTEX_W-1:0] coord;
  } cls_item_t;

  function automatic logic is_nan32(input logic [COORD_W-1:0] b);
    return b[COORD_W-2:0] > 31'h7F80_0000;
  endfunction

  function automatic logic is_zero32(input logic [COORD_W-1:0] b);
    return b[COORD_W-2:0] == '0;
  endfunction

endpackage

// ===== rtl/vdi_ram.sv =====
// ----------------------------------------------------------------------------
// vdi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vdi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/vdi_front.sv =====
// ----------------------------------------------------------------------------
// vdi_front
// Accepts vertex items, flags NaN and zero components, and buffers them in a
// two-entry queue toward the scan engine.
// ----------------------------------------------------------------------------
module vdi_front import vdi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      q_valid_o,
  output cls_item_t q_item_o,
  input  logic      q_pop_i
);

  localparam logic [1:0] QDepth = 2'd2;

  cls_item_t cls;
  cls_item_t entry_q [2];
  logic      wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic      push_ok, pop_ok;

  always_comb begin
    cls.start   = in_item_i.start_mesh;
    cls.coord   = {in_item_i.coord_x, in_item_i.coord_y, in_item_i.coord_z};
    cls.any_nan = is_nan32(in_item_i.coord_x) | is_nan32(in_item_i.coord_y) |
                  is_nan32(in_item_i.coord_z);
    cls.is_zero = {is_zero32(in_item_i.coord_x), is_zero32(in_item_i.coord_y),
                   is_zero32(in_item_i.coord_z)};
  end

  assign full      = (cnt_q == QDepth);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = entry_q[rd_ptr_q];
  assign push_ok   = push && !full;
  assign pop_ok    = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_ok) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push_ok, pop_ok})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/vdi_back.sv =====
// ----------------------------------------------------------------------------
// vdi_back
// Scan engine: walks the unique table one entry per cycle, then appends or
// reports, and holds the result item until it is popped.
// ----------------------------------------------------------------------------
module vdi_back import vdi_pkg::*; #(
  parameter int unsigned TableDepth = TABLE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  cls_item_t q_item_i,
  output logic      q_pop_o,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned CntW  = $clog2(TableDepth + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(TableDepth);

  typedef enum logic [1:0] {StIdle, StScan, StDone} state_e;

  state_e        state_q;
  cls_item_t     cur_q;
  logic [CntW-1:0] count_q, issue_q, cmp_idx_q, idx_q;
  logic          cmp_vld_q, hit_q, res_vld_q;
  out_item_t     res_q;

  logic [VERTEX_W-1:0] rd_data;
  logic [COORD_W-1:0]  sx, sy, sz, cx, cy, cz;
  logic          match, rd_en, out_ready, ram_we, res_load;

  always_comb begin
    sx = rd_data[3*COORD_W-1:2*COORD_W];
    sy = rd_data[2*COORD_W-1:COORD_W];
    sz = rd_data[COORD_W-1:0];
    cx = cur_q.coord[3*COORD_W-1:2*COORD_W];
    cy = cur_q.coord[2*COORD_W-1:COORD_W];
    cz = cur_q.coord[COORD_W-1:0];
    match = !is_nan32(sx) && !is_nan32(sy) && !is_nan32(sz) &&
            ((sx == cx) || (is_zero32(sx) && cur_q.is_zero[2])) &&
            ((sy == cy) || (is_zero32(sy) && cur_q.is_zero[1])) &&
            ((sz == cz) || (is_zero32(sz) && cur_q.is_zero[0]));
  end

  assign rd_en     = (state_q == StScan) && (issue_q != count_q);
  assign out_ready = !res_vld_q || pop;
  assign q_pop_o   = (state_q == StIdle) && q_valid_i;
  assign res_load  = (state_q == StDone) && out_ready;
  assign ram_we    = (state_q == StDone) && out_ready && !hit_q && (count_q != CntMax);
  assign empty     = !res_vld_q;
  assign out_item_o = res_q;

  vdi_ram #(
    .Width (VERTEX_W),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (cur_q.coord),
    .re_i    (rd_en),
    .raddr_i (issue_q[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      issue_q   <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (res_load) begin
        res_vld_q <= 1'b1;
      end else if (pop && res_vld_q) begin
        res_vld_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (q_valid_i) begin
            cur_q     <= q_item_i;
            issue_q   <= '0;
            cmp_vld_q <= 1'b0;
            hit_q     <= 1'b0;
            if (q_item_i.start) begin
              count_q <= '0;
            end
            state_q <= q_item_i.any_nan ? StDone : StScan;
          end
        end
        StScan: begin
          cmp_vld_q <= rd_en;
          cmp_idx_q <= issue_q;
          if (rd_en) begin
            issue_q <= issue_q + CntW'(1);
          end
          priority if (cmp_vld_q && match) begin
            hit_q   <= 1'b1;
            idx_q   <= cmp_idx_q;
            state_q <= StDone;
          end else if (issue_q == count_q) begin
            state_q <= StDone;
          end else begin
            state_q <= StScan;
          end
        end
        StDone: begin
          if (out_ready) begin
            priority if (hit_q) begin
              res_q <= '{vertex_index: INDEX_W'(idx_q), is_new: 1'b0,
                         table_overflow: 1'b0};
            end else if (count_q != CntMax) begin
              res_q <= '{vertex_index: INDEX_W'(count_q), is_new: 1'b1,
                         table_overflow: 1'b0};
              count_q <= count_q + CntW'(1);
            end else begin
              res_q <= '{vertex_index: '0, is_new: 1'b0, table_overflow: 1'b1};
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax) else $error("unique count above table depth");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> issue_q <= count_q) else $error("scan ran past count");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> count_q == $past(count_q) + CntW'(1))
    else $error("append without count increment");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> !(res_q.is_new && res_q.table_overflow))
    else $error("new and overflow both set");

  a_overflow_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.table_overflow |-> res_q.vertex_index == '0)
    else $error("overflow item with nonzero index");

endmodule

// ===== rtl/vertex_dedup_indexer_unit.sv =====
// ----------------------------------------------------------------------------
// vertex_dedup_indexer_unit
// Vertex deduplication: returns the unique-table index of each vertex.
// ----------------------------------------------------------------------------
// Each vertex item is looked up in a table of unique vertices kept in
// first-occurrence order; the result item gives the matching index, or the
// new index with is_new set, or index 0 with table_overflow set when the
// table is full. start_mesh empties the table before its vertex. A scan reads
// the stored entries in order and stops at the first match, or reads them all
// on a miss; the single read port of the table RAM reads one entry per cycle.
// A vertex with a NaN component skips the scan. A two-entry input queue and a
// result register let push and pop proceed independently of the scan. No
// clearing pass is needed after reset.
module vertex_dedup_indexer_unit import vdi_pkg::*; #(
  parameter int unsigned TableDepth = TABLE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic      q_valid, q_pop;
  cls_item_t q_item;

  vdi_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  vdi_back #(
    .TableDepth (TableDepth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vertex dedup indexer.
// A directed table covers signed zeros, NaN components, mesh restarts and
// extreme bit patterns. A fill run then packs the table with NaN vertices
// up to the last index and probes the full table. Random meshes follow under
// three idle profiles. Every result item is checked field by field against
// an in-bench model of the unique-vertex table or a pinned expected result.
// ----------------------------------------------------------------------------
module tb_top;
  import vdi_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 1100;

  localparam logic [31:0] F_PZERO    = 32'h0000_0000;
  localparam logic [31:0] F_NZERO    = 32'h8000_0000;
  localparam logic [31:0] F_ONE      = 32'h3F80_0000;
  localparam logic [31:0] F_TWO      = 32'h4000_0000;
  localparam logic [31:0] F_THREE    = 32'h4040_0000;
  localparam logic [31:0] F_QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] F_SNAN_MIN = 32'h7F80_0001;
  localparam logic [31:0] F_PINF     = 32'h7F80_0000;
  localparam logic [31:0] F_NINF     = 32'hFF80_0000;
  localparam logic [31:0] F_MAXNORM  = 32'h7F7F_FFFF;
  localparam logic [31:0] F_DENORM   = 32'h0000_0001;
  localparam logic [31:0] F_NDENORM  = 32'h8000_0001;
  localparam logic [31:0] F_ONES     = 32'hFFFF_FFFF;

  typedef struct {
    in_item_t  vtx;
    bit        pinned;
    out_item_t result;
  } vertex_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  // driver side-band: typed expectation travels with the item
  bit        drv_pinned;
  out_item_t drv_pinned_result;
  bit        vertex_taken;

  int unsigned send_idle_pct = 23;
  int unsigned recv_idle_pct = 67;
  int unsigned fail_count    = 0;
  int unsigned stall_cycles  = 0;

  // model of the unique-vertex table
  logic [31:0] tbl_x [TABLE_DEPTH];
  logic [31:0] tbl_y [TABLE_DEPTH];
  logic [31:0] tbl_z [TABLE_DEPTH];
  int unsigned stored_count = 0;

  out_item_t   expected_lookups [$];
  vertex_row_t directed_rows [$];

  vertex_dedup_indexer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic bit float_nan(input logic [31:0] c);
    return c[30:23] == 8'hFF && c[22:0] != 23'h0;
  endfunction

  function automatic bit float_equal(input logic [31:0] a, input logic [31:0] b);
    if (float_nan(a) || float_nan(b)) begin
      return 1'b0;
    end
    return a == b || (a[30:0] == 31'h0 && b[30:0] == 31'h0);
  endfunction

  function automatic out_item_t lookup_vertex(input in_item_t v);
    out_item_t   r;
    bit          found;
    int unsigned k;
    r     = '0;
    found = 1'b0;
    if (v.start_mesh) begin
      stored_count = 0;
    end
    for (k = 0; k < stored_count && !found; k++) begin
      if (float_equal(tbl_x[k], v.coord_x) && float_equal(tbl_y[k], v.coord_y) &&
          float_equal(tbl_z[k], v.coord_z)) begin
        r.vertex_index = k[INDEX_W-1:0];
        found          = 1'b1;
      end
    end
    if (!found) begin
      if (stored_count < TABLE_DEPTH) begin
        tbl_x[stored_count] = v.coord_x;
        tbl_y[stored_count] = v.coord_y;
        tbl_z[stored_count] = v.coord_z;
        r.vertex_index      = stored_count[INDEX_W-1:0];
        r.is_new            = 1'b1;
        stored_count++;
      end else begin
        r.table_overflow = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_nan();
    logic [31:0] r;
    r = $urandom();
    return {r[31], 8'hFF, (r[22:0] == 23'h0) ? 23'h1 : r[22:0]};
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(7))
      0:       return {r[31], 31'h0};
      1:       return rand_nan();
      2:       return {r[31], 8'hFF, 23'h0};
      3, 4:    return {r[31], 8'h7F + {6'h0, r[1:0]}, r[3:2], 21'h0};
      default: return r;
    endcase
  endfunction

  // a stored zero comes back with either sign
  function automatic logic [31:0] flip_zero(input logic [31:0] c);
    logic [31:0] r;
    r = $urandom();
    return (c[30:0] == 31'h0) ? {r[31], 31'h0} : c;
  endfunction

  function automatic in_item_t nan_vertex();
    in_item_t v;
    v.start_mesh = 1'b0;
    v.coord_x    = $urandom();
    v.coord_y    = $urandom();
    v.coord_z    = $urandom();
    case ($urandom_range(2))
      0:       v.coord_x = rand_nan();
      1:       v.coord_y = rand_nan();
      default: v.coord_z = rand_nan();
    endcase
    return v;
  endfunction

  function automatic in_item_t rand_vertex();
    in_item_t    v;
    int unsigned roll;
    int unsigned pick;
    roll         = $urandom_range(99);
    v.start_mesh = ($urandom_range(19) == 0);
    if (roll < 55 && stored_count != 0 && !v.start_mesh) begin
      pick      = $urandom_range(stored_count - 1);
      v.coord_x = flip_zero(tbl_x[pick]);
      v.coord_y = flip_zero(tbl_y[pick]);
      v.coord_z = flip_zero(tbl_z[pick]);
      // near miss: one component replaced
      if (roll < 12) begin
        case ($urandom_range(2))
          0:       v.coord_x = rand_coord();
          1:       v.coord_y = rand_coord();
          default: v.coord_z = rand_coord();
        endcase
      end
    end else begin
      v.coord_x = rand_coord();
      v.coord_y = rand_coord();
      v.coord_z = rand_coord();
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    fail_count++;
    if (fail_count <= 50) begin
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  task automatic add_row(input bit start, input logic [31:0] x, input logic [31:0] y,
                         input logic [31:0] z, input bit pinned, input int unsigned idx,
                         input bit fresh, input bit ovf);
    vertex_row_t row;
    row.vtx    = in_item_t'{start, x, y, z};
    row.pinned = pinned;
    row.result = out_item_t'{idx[INDEX_W-1:0], fresh, ovf};
    directed_rows = {directed_rows, row};
  endtask

  task automatic send_vertex(input in_item_t v, input bit pinned, input out_item_t result);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push              <= 1'b1;
    in_item           <= v;
    drv_pinned        <= pinned;
    drv_pinned_result <= result;
    do @(negedge clk_i); while (!vertex_taken);
  endtask

  task automatic drain_lookups();
    push <= 1'b0;
    do @(negedge clk_i); while (expected_lookups.size() != 0);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) begin
      send_vertex(rand_vertex(), 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end else begin
      pop <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    bit        moved;
    if (rst_ni) begin
      moved        = 1'b0;
      vertex_taken = 1'b0;
      if (pop && !empty) begin
        moved = 1'b1;
        if (expected_lookups.size() == 0) begin
          report_mismatch("result with nothing expected", 32'(out_item), 0);
        end else begin
          want = expected_lookups.pop_front();
          if (out_item.vertex_index !== want.vertex_index) begin
            report_mismatch("vertex_index", 32'(out_item.vertex_index),
                            32'(want.vertex_index));
          end
          if (out_item.is_new !== want.is_new) begin
            report_mismatch("is_new", 32'(out_item.is_new), 32'(want.is_new));
          end
          if (out_item.table_overflow !== want.table_overflow) begin
            report_mismatch("table_overflow", 32'(out_item.table_overflow),
                            32'(want.table_overflow));
          end
        end
      end
      if (push && !full) begin
        moved        = 1'b1;
        vertex_taken = 1'b1;
        want         = lookup_vertex(in_item);
        if (drv_pinned) begin
          want = drv_pinned_result;
        end
        expected_lookups = {expected_lookups, want};
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int r;
    rst_ni            = 1'b0;
    push              = 1'b0;
    in_item           = '0;
    drv_pinned        = 1'b0;
    drv_pinned_result = '0;

    add_row(1, F_ONE,     F_TWO,   F_THREE,    1, 0, 1, 0);
    add_row(0, F_ONE,     F_TWO,   F_THREE,    1, 0, 0, 0);
    add_row(0, F_PZERO,   F_PZERO, F_PZERO,    1, 1, 1, 0);
    add_row(0, F_NZERO,   F_NZERO, F_NZERO,    1, 1, 0, 0);
    add_row(0, F_NZERO,   F_PZERO, F_NZERO,    1, 1, 0, 0);
    add_row(0, F_QNAN,    F_PZERO, F_PZERO,    1, 2, 1, 0);
    add_row(0, F_QNAN,    F_PZERO, F_PZERO,    1, 3, 1, 0);
    add_row(0, F_PZERO,   F_ONES,  F_PZERO,    0, 0, 0, 0);
    add_row(0, F_ONES,    F_ONES,  F_ONES,     0, 0, 0, 0);
    add_row(0, F_PINF,    F_NINF,  F_MAXNORM,  1, 6, 1, 0);
    add_row(0, F_PINF,    F_NINF,  F_MAXNORM,  1, 6, 0, 0);
    add_row(0, F_DENORM,  F_PZERO, F_PZERO,    1, 7, 1, 0);
    add_row(0, F_NDENORM, F_PZERO, F_PZERO,    1, 8, 1, 0);
    add_row(0, F_DENORM,  F_NZERO, F_NZERO,    0, 0, 0, 0);
    add_row(0, F_PZERO,   F_PZERO, F_SNAN_MIN, 1, 9, 1, 0);
    add_row(0, F_ONE,     F_TWO,   F_THREE,    1, 0, 0, 0);
    add_row(1, F_PZERO,   F_PZERO, F_PZERO,    1, 0, 1, 0);
    add_row(0, F_ONE,     F_TWO,   F_THREE,    1, 1, 1, 0);
    add_row(1, F_ONE,     F_TWO,   F_THREE,    1, 0, 1, 0);
    add_row(0, F_NZERO,   F_NZERO, F_NZERO,    1, 1, 1, 0);
    add_row(0, F_PZERO,   F_PZERO, F_PZERO,    1, 1, 0, 0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (r = 0; r < directed_rows.size(); r++) begin
      send_vertex(directed_rows[r].vtx, directed_rows[r].pinned, directed_rows[r].result);
    end

    // fill to the last index with NaN vertices, then probe the full table
    send_vertex(in_item_t'{1'b1, F_ONE, F_TWO, F_THREE}, 1'b1, out_item_t'{10'd0, 1'b1, 1'b0});
    send_vertex(in_item_t'{1'b0, F_NZERO, F_PZERO, F_PINF}, 1'b1,
                out_item_t'{10'd1, 1'b1, 1'b0});
    while (stored_count < TABLE_DEPTH) begin
      send_vertex(nan_vertex(), 1'b0, '0);
    end
    send_vertex(in_item_t'{1'b0, F_ONE, F_TWO, F_THREE}, 1'b1, out_item_t'{10'd0, 1'b0, 1'b0});
    send_vertex(in_item_t'{1'b0, F_PZERO, F_NZERO, F_PINF}, 1'b1,
                out_item_t'{10'd1, 1'b0, 1'b0});
    send_vertex(in_item_t'{1'b0, F_ONE, F_ONE, F_ONE}, 1'b1, out_item_t'{10'd0, 1'b0, 1'b1});
    send_vertex(nan_vertex(), 1'b0, '0);
    send_vertex(in_item_t'{1'b0, F_PZERO, F_PZERO, F_PZERO}, 1'b1,
                out_item_t'{10'd0, 1'b0, 1'b1});

    send_random(195);
    drain_lookups();
    send_idle_pct = 67;
    recv_idle_pct = 23;
    send_random(195);
    drain_lookups();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(190);
    drain_lookups();

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
